// ----- rtl/dht_pkg.sv -----
package dht_pkg;

  // loss rate fixed point
  localparam int RATE_FRAC_BITS = 16;

  // time constants
  localparam logic [31:0] NS_PER_S = 32'd1000000000;
  localparam logic [31:0] HALF_S   = 32'd500000000;

  // divider size
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [1:0] CFG_PPS_OFFSET = 2'd0;
  localparam logic [1:0] CFG_FRAG_PERIOD = 2'd1;
  localparam logic [1:0] CFG_MAX_GAP = 2'd2;
  localparam logic [1:0] CFG_MAX_T0 = 2'd3;

  // configuration reset values
  localparam logic [30:0] PPS_OFFSET_RST = 31'd0;
  localparam logic [31:0] FRAG_PERIOD_RST = 32'd1000000;
  localparam logic [31:0] MAX_GAP_RST = 32'd0;
  localparam logic [29:0] MAX_T0_RST = 30'd1000000000;

  typedef enum logic [1:0] {
    REQ_OPEN  = 2'd0,
    REQ_HIT   = 2'd1,
    REQ_CLOSE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_FRAG = 2'd1,
    KIND_SUM  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [30:0] pps_offset;
    logic [31:0] frag_period;
    logic [31:0] max_gap;
    logic [29:0] max_t0;
  } cfg_t;

  // one classified request waiting for the back end
  typedef struct packed {
    req_e        req;
    logic [63:0] mean;
    logic [29:0] ts0;
    logic [29:0] raw;
    logic [15:0] lost_cpu;
    logic [15:0] lost_fpga;
  } entry_t;

endpackage

// ----- rtl/detector_hit_timestamper_core.sv -----
// Work per request: a poll open folds the mean modulo one second and, after a poll
// with hits, runs one 64-step division for the loss rate; a hit runs one 64-step division
// for the fragment index, then the fragment centre states when a fragment closes; a poll
// close gives any open fragment result and the summary; any output stall holds each.
// Throughput: one request at a time in the back end, set by the shared 64-step
// divider; a two-entry queue takes new requests while the back end works.
// Reset: rst_ni low clears the sequencer, queue pointers and block state at once and loads the register defaults.
module detector_hit_timestamper_core import dht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] window_start_ns_i,
  input  logic [63:0] window_end_ns_i,
  input  logic [29:0] raw_ns_counter_i,
  input  logic [15:0] lost_cpu_i,
  input  logic [15:0] lost_fpga_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [63:0] time_ns_o,
  output logic [31:0] lost_estimate_o,
  output logic [63:0] hit_serial_o,
  output logic [63:0] previous_time_ns_o,
  output logic        gap_warning_o,
  output logic [15:0] fragment_count_o,
  output logic [31:0] poll_hit_total_o,
  output logic        no_hits_flag_o,
  output logic        pps_missing_o,
  output logic        is_last_o
);

  cfg_t   cfg_q;
  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   pop;
  logic   empty;
  logic   full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pps_offset  <= PPS_OFFSET_RST;
      cfg_q.frag_period <= FRAG_PERIOD_RST;
      cfg_q.max_gap     <= MAX_GAP_RST;
      cfg_q.max_t0      <= MAX_T0_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PPS_OFFSET:  cfg_q.pps_offset  <= cfg_data_i[30:0];
        CFG_FRAG_PERIOD: cfg_q.frag_period <= cfg_data_i;
        CFG_MAX_GAP:     cfg_q.max_gap     <= cfg_data_i;
        CFG_MAX_T0:      cfg_q.max_t0      <= cfg_data_i[29:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  dht_front u_front (
    .pps_offset_i      (cfg_q.pps_offset),
    .in_valid_i        (in_valid_i),
    .req_type_i        (req_type_i),
    .window_start_ns_i (window_start_ns_i),
    .window_end_ns_i   (window_end_ns_i),
    .raw_ns_counter_i  (raw_ns_counter_i),
    .lost_cpu_i        (lost_cpu_i),
    .lost_fpga_i       (lost_fpga_i),
    .full_i            (full),
    .push_o            (push),
    .entry_o           (push_entry),
    .in_stall_o        (in_stall_o)
  );

  dht_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  dht_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .entry_i            (head_entry),
    .empty_i            (empty),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .result_kind_o      (result_kind_o),
    .time_ns_o          (time_ns_o),
    .lost_estimate_o    (lost_estimate_o),
    .hit_serial_o       (hit_serial_o),
    .previous_time_ns_o (previous_time_ns_o),
    .gap_warning_o      (gap_warning_o),
    .fragment_count_o   (fragment_count_o),
    .poll_hit_total_o   (poll_hit_total_o),
    .no_hits_flag_o     (no_hits_flag_o),
    .pps_missing_o      (pps_missing_o),
    .is_last_o          (is_last_o)
  );

endmodule

// ----- rtl/dht_front.sv -----
module dht_front import dht_pkg::*; (
  input  logic [30:0] pps_offset_i,
  input  logic        in_valid_i,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] window_start_ns_i,
  input  logic [63:0] window_end_ns_i,
  input  logic [29:0] raw_ns_counter_i,
  input  logic [15:0] lost_cpu_i,
  input  logic [15:0] lost_fpga_i,
  input  logic        full_i,
  output logic        push_o,
  output entry_t      entry_o,
  output logic        in_stall_o
);

  localparam logic signed [32:0] S1 = 33'sd1000000000;
  localparam logic signed [32:0] S2 = 33'sd2000000000;

  logic signed [32:0] sum;
  logic signed [32:0] ts;
  req_e               req;

  assign req = req_e'(req_type_i);

  // counter plus cable offset, folded into one second
  always_comb begin
    sum = $signed({3'b000, raw_ns_counter_i}) + $signed({{2{pps_offset_i[30]}}, pps_offset_i});
    if (sum < 0) begin
      ts = ((sum + S1) < 0) ? (sum + S2) : (sum + S1);
    end else if (sum >= S2) begin
      ts = sum - S2;
    end else if (sum >= S1) begin
      ts = sum - S1;
    end else begin
      ts = sum;
    end
  end

  // build queue entry
  always_comb begin
    entry_o.req       = req;
    entry_o.mean      = {1'b0, window_start_ns_i[63:1]} + {1'b0, window_end_ns_i[63:1]};
    entry_o.ts0       = ts[29:0];
    entry_o.raw       = raw_ns_counter_i;
    entry_o.lost_cpu  = lost_cpu_i;
    entry_o.lost_fpga = lost_fpga_i;
  end

  // unused request code is taken and dropped
  assign push_o     = in_valid_i && !full_i && (req inside {REQ_OPEN, REQ_HIT, REQ_CLOSE});
  assign in_stall_o = full_i;

endmodule

// ----- rtl/dht_queue.sv -----
module dht_queue import dht_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o,
  output logic   full_o
);

  entry_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign entry_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/dht_div.sv -----
module dht_div import dht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);

  logic [63:0]          quot_q;
  logic [31:0]          rem_q;
  logic [31:0]          divisor_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [32:0]          rem_sh;
  logic [33:0]          diff;

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_q, quot_q[63]};
    diff   = {1'b0, rem_sh} - {2'b00, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q    <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_q  <= diff[31:0];
        quot_q <= {quot_q[62:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[31:0];
        quot_q <= {quot_q[62:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- rtl/dht_back.sv -----
module dht_back import dht_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  entry_t      entry_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [63:0] time_ns_o,
  output logic [31:0] lost_estimate_o,
  output logic [63:0] hit_serial_o,
  output logic [63:0] previous_time_ns_o,
  output logic        gap_warning_o,
  output logic [15:0] fragment_count_o,
  output logic [31:0] poll_hit_total_o,
  output logic        no_hits_flag_o,
  output logic        pps_missing_o,
  output logic        is_last_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_OPEN_MOD  = 4'd1;
  localparam logic [3:0] S_OPEN_RATE = 4'd2;
  localparam logic [3:0] S_HIT_A     = 4'd3;
  localparam logic [3:0] S_HIT_B     = 4'd4;
  localparam logic [3:0] S_HIT_DIV   = 4'd5;
  localparam logic [3:0] S_CEN_LO    = 4'd6;
  localparam logic [3:0] S_CEN_HI    = 4'd7;
  localparam logic [3:0] S_FRAG      = 4'd8;
  localparam logic [3:0] S_HIT_OUT   = 4'd9;
  localparam logic [3:0] S_SUM_OUT   = 4'd10;

  localparam logic [31:0] RATE_ONE = 32'(64'd1 << RATE_FRAC_BITS);

  // 2^30 modulo one second, folds the upper bits back into the residue
  localparam logic [26:0] SEC_FOLD = 27'd73741824;

  logic [3:0]  state_q;
  entry_t      cmd_q;

  // block state
  logic [63:0] mean_base_q;
  logic [29:0] mns_q;
  logic [15:0] prev_lfpga_q;
  logic [63:0] hit_cnt_q;
  logic [63:0] last_time_q;
  logic [31:0] rate_q;
  logic [15:0] read_hits_q;
  logic [31:0] lost_total_q;
  logic [29:0] max_raw_q;
  logic [63:0] start_serial_q;
  logic [63:0] win_idx_q;
  logic [15:0] win_hits_q;

  // per item work registers
  logic [63:0] t_q;
  logic [31:0] lost_q;
  logic [63:0] prev_q;
  logic        gap_q;
  logic [63:0] widx_q;
  logic [63:0] cen_lo_q;
  logic [31:0] cen_hi_q;
  logic [63:0] fold_q;

  // output register
  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [63:0] out_time_q;
  logic [31:0] out_lost_q;
  logic [63:0] out_serial_q;
  logic [63:0] out_prev_q;
  logic        out_gap_q;
  logic [15:0] out_fcount_q;
  logic [31:0] out_ptotal_q;
  logic        out_nohits_q;
  logic        out_pps_q;
  logic        out_last_q;

  logic        out_free;
  logic        out_load;
  logic [31:0] period;
  logic        div_start;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [63:0] div_quot;
  logic [32:0] rate_sum;

  logic [60:0] fold_prod;
  logic [63:0] fold_next;
  logic        fold_done;
  logic [29:0] mod_rem;

  logic signed [30:0] dlt;
  logic [63:0] t_base;
  logic [63:0] t_new;
  logic [47:0] lost_prod;
  logic [48:0] lost_sum;
  logic [31:0] lost_new;
  logic [32:0] total_sum;
  logic [63:0] cen_lo;
  logic [31:0] cen_hi;

  assign period   = (cfg_i.frag_period == '0) ? 32'd1 : cfg_i.frag_period;
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free && (state_q inside {S_FRAG, S_HIT_OUT, S_SUM_OUT});
  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign rate_sum = {1'b0, lost_total_q} + {17'b0, read_hits_q};

  // mean modulo one second: fold bits above 2^30 until none are left
  assign fold_prod = {27'b0, fold_q[63:30]} * {34'b0, SEC_FOLD};
  assign fold_next = {3'b0, fold_prod} + {34'b0, fold_q[29:0]};
  assign fold_done = (fold_q[63:30] == '0);
  assign mod_rem   = (fold_q[29:0] >= NS_PER_S[29:0]) ? (fold_q[29:0] - NS_PER_S[29:0])
                                                      : fold_q[29:0];

  // shared divider: loss rate and fragment index
  always_comb begin
    div_start    = 1'b0;
    div_dividend = t_q;
    div_divisor  = period;
    case (state_q)
      S_OPEN_MOD: begin
        div_start    = fold_done && (read_hits_q != '0);
        div_dividend = 64'(rate_sum) << RATE_FRAC_BITS;
        div_divisor  = {16'b0, read_hits_q};
      end
      S_HIT_B: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  dht_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // hit time in the second nearest the mean poll time, and loss estimate
  always_comb begin
    dlt    = $signed({1'b0, cmd_q.ts0}) - $signed({1'b0, mns_q});
    t_base = mean_base_q + {34'b0, cmd_q.ts0};
    if (dlt < -$signed({1'b0, HALF_S[29:0]})) begin
      t_new = t_base + {32'b0, NS_PER_S};
    end else if (dlt > $signed({1'b0, HALF_S[29:0]})) begin
      t_new = t_base - {32'b0, NS_PER_S};
    end else begin
      t_new = t_base;
    end
    lost_prod = {32'b0, cmd_q.lost_cpu} * {16'b0, rate_q};
    lost_sum  = 49'(lost_prod >> RATE_FRAC_BITS) + {33'b0, prev_lfpga_q};
    lost_new  = (lost_sum[48:32] != '0) ? 32'hFFFF_FFFF : lost_sum[31:0];
    total_sum = {1'b0, lost_total_q} + {17'b0, prev_lfpga_q};
  end

  // fragment centre partial products
  assign cen_lo = {32'b0, win_idx_q[31:0]} * {32'b0, period};
  assign cen_hi = win_idx_q[63:32] * period;

  // sequencer and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      mean_base_q    <= '0;
      mns_q          <= '0;
      prev_lfpga_q   <= '0;
      hit_cnt_q      <= '0;
      last_time_q    <= '0;
      rate_q         <= RATE_ONE;
      read_hits_q    <= '0;
      lost_total_q   <= '0;
      max_raw_q      <= '0;
      start_serial_q <= '0;
      win_idx_q      <= '0;
      win_hits_q     <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            case (entry_i.req)
              REQ_OPEN:  state_q <= S_OPEN_MOD;
              REQ_HIT:   state_q <= S_HIT_A;
              REQ_CLOSE: state_q <= (win_hits_q != '0) ? S_CEN_LO : S_SUM_OUT;
              default:   state_q <= S_IDLE;
            endcase
          end
        end
        S_OPEN_MOD: begin
          if (fold_done) begin
            mns_q       <= mod_rem;
            mean_base_q <= cmd_q.mean - {34'b0, mod_rem};
            if (read_hits_q == '0) begin
              rate_q         <= RATE_ONE;
              read_hits_q    <= '0;
              lost_total_q   <= '0;
              max_raw_q      <= '0;
              start_serial_q <= hit_cnt_q;
              win_hits_q     <= '0;
              state_q        <= S_IDLE;
            end else begin
              state_q <= S_OPEN_RATE;
            end
          end
        end
        S_OPEN_RATE: begin
          if (div_done) begin
            rate_q         <= (div_quot[63:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
            read_hits_q    <= '0;
            lost_total_q   <= '0;
            max_raw_q      <= '0;
            start_serial_q <= hit_cnt_q;
            win_hits_q     <= '0;
            state_q        <= S_IDLE;
          end
        end
        S_HIT_A: begin
          if (cmd_q.raw > max_raw_q) begin
            max_raw_q <= cmd_q.raw;
          end
          lost_total_q <= total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
          prev_lfpga_q <= cmd_q.lost_fpga;
          if (read_hits_q != 16'hFFFF) begin
            read_hits_q <= read_hits_q + 1'b1;
          end
          state_q <= S_HIT_B;
        end
        S_HIT_B: begin
          hit_cnt_q   <= hit_cnt_q + {32'b0, lost_q} + 64'd1;
          last_time_q <= t_q;
          state_q     <= S_HIT_DIV;
        end
        S_HIT_DIV: begin
          if (div_done) begin
            state_q <= ((win_hits_q != '0) && (div_quot != win_idx_q)) ? S_CEN_LO : S_HIT_OUT;
          end
        end
        S_CEN_LO: begin
          state_q <= S_CEN_HI;
        end
        S_CEN_HI: begin
          state_q <= S_FRAG;
        end
        S_FRAG: begin
          if (out_free) begin
            state_q <= (cmd_q.req == REQ_HIT) ? S_HIT_OUT : S_SUM_OUT;
          end
        end
        S_HIT_OUT: begin
          if (out_free) begin
            if ((win_hits_q == '0) || (widx_q != win_idx_q)) begin
              win_idx_q  <= widx_q;
              win_hits_q <= 16'd1;
            end else if (win_hits_q != 16'hFFFF) begin
              win_hits_q <= win_hits_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        S_SUM_OUT: begin
          if (out_free) begin
            win_hits_q <= '0;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= entry_i;
      fold_q <= entry_i.mean;
    end else if ((state_q == S_OPEN_MOD) && !fold_done) begin
      fold_q <= fold_next;
    end
    if (state_q == S_HIT_A) begin
      t_q    <= t_new;
      lost_q <= lost_new;
    end
    if (state_q == S_HIT_B) begin
      prev_q <= last_time_q;
      gap_q  <= (cfg_i.max_gap != '0) && (last_time_q > 64'd1) &&
                ((t_q - last_time_q) > {32'b0, cfg_i.max_gap});
    end
    if ((state_q == S_HIT_DIV) && div_done) begin
      widx_q <= div_quot;
    end
    if (state_q == S_CEN_LO) begin
      cen_lo_q <= cen_lo;
    end
    if (state_q == S_CEN_HI) begin
      cen_hi_q <= cen_hi;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      case (state_q)
        S_FRAG: begin
          out_kind_q   <= KIND_FRAG;
          out_time_q   <= cen_lo_q + {cen_hi_q, 32'b0} + {33'b0, period[31:1]};
          out_lost_q   <= '0;
          out_serial_q <= '0;
          out_prev_q   <= '0;
          out_gap_q    <= 1'b0;
          out_fcount_q <= win_hits_q;
          out_ptotal_q <= '0;
          out_nohits_q <= 1'b0;
          out_pps_q    <= 1'b0;
          out_last_q   <= 1'b0;
        end
        S_HIT_OUT: begin
          out_kind_q   <= KIND_HIT;
          out_time_q   <= t_q;
          out_lost_q   <= lost_q;
          out_serial_q <= hit_cnt_q;
          out_prev_q   <= prev_q;
          out_gap_q    <= gap_q;
          out_fcount_q <= '0;
          out_ptotal_q <= '0;
          out_nohits_q <= 1'b0;
          out_pps_q    <= 1'b0;
          out_last_q   <= 1'b1;
        end
        S_SUM_OUT: begin
          out_kind_q   <= KIND_SUM;
          out_time_q   <= '0;
          out_lost_q   <= '0;
          out_serial_q <= '0;
          out_prev_q   <= '0;
          out_gap_q    <= 1'b0;
          out_fcount_q <= '0;
          out_ptotal_q <= 32'(hit_cnt_q - start_serial_q);
          out_nohits_q <= (read_hits_q == '0);
          out_pps_q    <= (max_raw_q > cfg_i.max_t0);
          out_last_q   <= 1'b1;
        end
        default: begin
          out_kind_q <= out_kind_q;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_kind_o      = out_kind_q;
  assign time_ns_o          = out_time_q;
  assign lost_estimate_o    = out_lost_q;
  assign hit_serial_o       = out_serial_q;
  assign previous_time_ns_o = out_prev_q;
  assign gap_warning_o      = out_gap_q;
  assign fragment_count_o   = out_fcount_q;
  assign poll_hit_total_o   = out_ptotal_q;
  assign no_hits_flag_o     = out_nohits_q;
  assign pps_missing_o      = out_pps_q;
  assign is_last_o          = out_last_q;

endmodule

// ----- test/detector_hit_timestamper_core_tb.sv -----
`timescale 1ns / 1ps

module detector_hit_timestamper_core_tb;
  import dht_pkg::*;

  // request code that the block ignores
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint     SECOND_NS = 1000000000;
  localparam longint     HALF_SECOND_NS = 500000000;
  localparam int         IDLE_PCT = 17;
  localparam int         SETTLE_CYCLES = 300;

  typedef struct {
    logic [1:0]  req;
    logic [63:0] win_start;
    logic [63:0] win_end;
    logic [29:0] raw;
    logic [15:0] lost_cpu;
    logic [15:0] lost_fpga;
  } board_req_t;

  typedef struct {
    kind_e       kind;
    logic [63:0] time_ns;
    logic [31:0] lost;
    logic [63:0] serial;
    logic [63:0] prev_time;
    logic        gap;
    logic [15:0] frag_count;
    logic [31:0] poll_total;
    logic        no_hits;
    logic        pps_missing;
    logic        last;
  } stamp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  req_type_i;
  logic [63:0] window_start_ns_i;
  logic [63:0] window_end_ns_i;
  logic [29:0] raw_ns_counter_i;
  logic [15:0] lost_cpu_i;
  logic [15:0] lost_fpga_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [63:0] time_ns_o;
  logic [31:0] lost_estimate_o;
  logic [63:0] hit_serial_o;
  logic [63:0] previous_time_ns_o;
  logic        gap_warning_o;
  logic [15:0] fragment_count_o;
  logic [31:0] poll_hit_total_o;
  logic        no_hits_flag_o;
  logic        pps_missing_o;
  logic        is_last_o;

  detector_hit_timestamper_core dut (.*);

  board_req_t pending_reqs[$];
  stamp_t     expected_stamps[$];
  board_req_t drv_req;
  int         err_count;
  int         n_hit_stamps, n_frag_stamps, n_summaries;
  bit         calm;
  bit         in_took;

  // local copy of registers and state
  logic [30:0] pps_offset;
  logic [31:0] frag_period;
  logic [31:0] max_gap;
  logic [29:0] max_t0;
  logic [63:0] mean_time, hit_count, last_time, poll_first_serial, win_index;
  logic [15:0] prev_fpga, poll_hits, win_hits;
  logic [31:0] loss_rate, poll_lost;
  logic [29:0] poll_max_raw;

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic void apply_cfg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      CFG_PPS_OFFSET:  pps_offset = data[30:0];
      CFG_FRAG_PERIOD: frag_period = data;
      CFG_MAX_GAP:     max_gap = data;
      default:         max_t0 = data[29:0];
    endcase
  endfunction

  function automatic stamp_t blank_stamp(kind_e kind);
    stamp_t s;
    s = '{kind: kind, default: '0};
    return s;
  endfunction

  function automatic logic [63:0] frag_centre(logic [63:0] per);
    return win_index * per + per / 2;
  endfunction

  // expected stamps for one accepted request
  function automatic void timestamp_request(board_req_t r);
    stamp_t      s;
    logic [63:0] per, rate_q, t, mod_mean, widx, lost_w;
    longint      off, ts0, d;
    per = (frag_period == 0) ? 64'd1 : {32'd0, frag_period};
    case (r.req)
      REQ_OPEN: begin
        mean_time = r.win_start / 2 + r.win_end / 2;
        if (poll_hits == 0) loss_rate = 32'd1 << RATE_FRAC_BITS;
        else begin
          rate_q = (({32'd0, poll_lost} + poll_hits) << RATE_FRAC_BITS) / poll_hits;
          loss_rate = (rate_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rate_q[31:0];
        end
        poll_hits = 0;
        poll_lost = 0;
        poll_max_raw = 0;
        poll_first_serial = hit_count;
        win_hits = 0;
      end
      REQ_HIT: begin
        off = {{33{pps_offset[30]}}, pps_offset};
        ts0 = (longint'({34'd0, r.raw}) + off) % SECOND_NS;
        if (ts0 < 0) ts0 += SECOND_NS;
        mod_mean = mean_time % 64'd1000000000;
        t = mean_time - mod_mean + ts0;
        d = ts0 - longint'(mod_mean);
        if (d < -HALF_SECOND_NS) t += SECOND_NS;
        if (d > HALF_SECOND_NS) t -= SECOND_NS;
        if (r.raw > poll_max_raw) poll_max_raw = r.raw;
        poll_lost = ({1'b0, poll_lost} + prev_fpga > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : poll_lost + prev_fpga;
        lost_w = ((64'(r.lost_cpu) * loss_rate) >> RATE_FRAC_BITS) + prev_fpga;
        if (lost_w > 64'hFFFF_FFFF) lost_w = 64'hFFFF_FFFF;
        prev_fpga = r.lost_fpga;
        hit_count += 1 + lost_w;
        s = blank_stamp(KIND_HIT);
        s.time_ns = t;
        s.lost = lost_w[31:0];
        s.serial = hit_count;
        s.prev_time = last_time;
        s.gap = (max_gap != 0) && (last_time > 1) && ((t - last_time) > max_gap);
        s.last = 1'b1;
        last_time = t;
        if (poll_hits != 16'hFFFF) poll_hits++;
        widx = t / per;
        if (win_hits == 0) begin
          win_index = widx;
          win_hits = 1;
        end else if (widx == win_index) begin
          if (win_hits != 16'hFFFF) win_hits++;
        end else begin
          stamp_t f;
          f = blank_stamp(KIND_FRAG);
          f.time_ns = frag_centre(per);
          f.frag_count = win_hits;
          expected_stamps.insert(expected_stamps.size(), f);
          win_index = widx;
          win_hits = 1;
        end
        expected_stamps.insert(expected_stamps.size(), s);
      end
      REQ_CLOSE: begin
        if (win_hits != 0) begin
          s = blank_stamp(KIND_FRAG);
          s.time_ns = frag_centre(per);
          s.frag_count = win_hits;
          expected_stamps.insert(expected_stamps.size(), s);
          win_hits = 0;
        end
        s = blank_stamp(KIND_SUM);
        s.poll_total = 32'(hit_count - poll_first_serial);
        s.no_hits = (poll_hits == 0);
        s.pps_missing = (poll_max_raw > max_t0);
        s.last = 1'b1;
        expected_stamps.insert(expected_stamps.size(), s);
      end
      default: ;
    endcase
  endfunction

  // driver: new transfer or idle at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          drv_req = pending_reqs.pop_front();
          req_type_i <= drv_req.req;
          window_start_ns_i <= drv_req.win_start;
          window_end_ns_i <= drv_req.win_end;
          raw_ns_counter_i <= drv_req.raw;
          lost_cpu_i <= drv_req.lost_cpu;
          lost_fpga_i <= drv_req.lost_fpga;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // monitor: predict on input transfers, check output transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took = in_valid_i && !in_stall_o;
      if (cfg_we_i) apply_cfg(cfg_idx_i, cfg_data_i);
      if (in_took)
        timestamp_request('{req_type_i, window_start_ns_i, window_end_ns_i,
                            raw_ns_counter_i, lost_cpu_i, lost_fpga_i});
      if (out_valid_o && !out_stall_i) begin
        if (expected_stamps.size() == 0) begin
          report_mismatch("unexpected result kind", result_kind_o, 0);
        end else begin
          stamp_t w;
          w = expected_stamps.pop_front();
          case (w.kind)
            KIND_HIT:  n_hit_stamps++;
            KIND_FRAG: n_frag_stamps++;
            default:   n_summaries++;
          endcase
          if (result_kind_o !== w.kind) report_mismatch("result_kind", result_kind_o, w.kind);
          if (time_ns_o !== w.time_ns) report_mismatch("time_ns", time_ns_o, w.time_ns);
          if (lost_estimate_o !== w.lost) report_mismatch("lost_estimate", lost_estimate_o, w.lost);
          if (hit_serial_o !== w.serial) report_mismatch("hit_serial", hit_serial_o, w.serial);
          if (previous_time_ns_o !== w.prev_time)
            report_mismatch("previous_time_ns", previous_time_ns_o, w.prev_time);
          if (gap_warning_o !== w.gap) report_mismatch("gap_warning", gap_warning_o, w.gap);
          if (fragment_count_o !== w.frag_count)
            report_mismatch("fragment_count", fragment_count_o, w.frag_count);
          if (poll_hit_total_o !== w.poll_total)
            report_mismatch("poll_hit_total", poll_hit_total_o, w.poll_total);
          if (no_hits_flag_o !== w.no_hits) report_mismatch("no_hits_flag", no_hits_flag_o, w.no_hits);
          if (pps_missing_o !== w.pps_missing)
            report_mismatch("pps_missing", pps_missing_o, w.pps_missing);
          if (is_last_o !== w.last) report_mismatch("is_last", is_last_o, w.last);
        end
      end
    end
  end

  function automatic void add_req(logic [1:0] req, logic [63:0] ws, logic [63:0] we,
                                  logic [29:0] raw, logic [15:0] lc, logic [15:0] lf);
    pending_reqs.insert(pending_reqs.size(), '{req, ws, we, raw, lc, lf});
  endfunction

  function automatic logic [29:0] rand_raw();
    return ($urandom_range(99) < 85) ? 30'($urandom_range(0, 999999999)) : 30'($urandom);
  endfunction

  function automatic logic [15:0] rand_loss();
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return '0;
    if (roll < 85) return 16'($urandom_range(1, 5));
    return 16'($urandom);
  endfunction

  function automatic void add_hit();
    add_req(REQ_HIT, {$urandom, $urandom}, {$urandom, $urandom}, rand_raw(),
            rand_loss(), rand_loss());
  endfunction

  // one well formed poll with random content, sometimes broken by noise
  function automatic void add_poll();
    logic [63:0] ws, we;
    int          nhits, roll;
    ws = {$urandom, $urandom};
    if ($urandom_range(9) == 0) ws = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 2000000000);
    else if ($urandom_range(9) == 0) ws = $urandom_range(0, 2000000000);
    we = ($urandom_range(9) == 0) ? {$urandom, $urandom} : ws + $urandom_range(0, 2000000000);
    nhits = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
    add_req(REQ_OPEN, ws, we, 30'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < nhits; i++) begin
      roll = $urandom_range(99);
      if (roll < 2) add_req(REQ_UNUSED, {$urandom, $urandom}, {$urandom, $urandom},
                            30'($urandom), 16'($urandom), 16'($urandom));
      else if (roll < 4) add_req(REQ_CLOSE, 0, 0, 0, 0, 0);
      add_hit();
    end
    if ($urandom_range(19) != 0) add_req(REQ_CLOSE, {$urandom, $urandom}, 0, 0, 0, 0);
    else add_hit();
  endfunction

  task automatic write_cfg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all_cfg(int pps, logic [31:0] per, logic [31:0] gap, logic [29:0] t0);
    write_cfg(CFG_PPS_OFFSET, 32'(pps));
    write_cfg(CFG_FRAG_PERIOD, per);
    write_cfg(CFG_MAX_GAP, gap);
    write_cfg(CFG_MAX_T0, {2'b00, t0});
  endtask

  // let every queued request go through and the back end settle
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_stamps.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_polls(int n_reqs);
    int start;
    start = pending_reqs.size();
    while (pending_reqs.size() - start < n_reqs) add_poll();
    drain();
  endtask

  initial begin
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PPS_OFFSET;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    req_type_i = REQ_OPEN;
    window_start_ns_i = '0;
    window_end_ns_i = '0;
    raw_ns_counter_i = '0;
    lost_cpu_i = '0;
    lost_fpga_i = '0;
    in_took = 1'b0;
    calm = 1'b0;
    err_count = 0;
    pps_offset = PPS_OFFSET_RST;
    frag_period = FRAG_PERIOD_RST;
    max_gap = MAX_GAP_RST;
    max_t0 = MAX_T0_RST;
    mean_time = 0;
    hit_count = 0;
    last_time = 0;
    poll_first_serial = 0;
    win_index = 0;
    prev_fpga = 0;
    poll_hits = 0;
    win_hits = 0;
    loss_rate = 32'd1 << RATE_FRAC_BITS;
    poll_lost = 0;
    poll_max_raw = 0;
    @(posedge rst_ni);

    // directed: hits and close before any open, extremes, ignored code
    add_req(REQ_HIT, 0, 0, 0, 0, 0);
    add_req(REQ_CLOSE, 0, 0, 0, 0, 0);
    add_req(REQ_CLOSE, 0, 0, 0, 0, 0);
    add_req(REQ_UNUSED, '1, '1, '1, '1, '1);
    add_req(REQ_OPEN, '1, '1, 0, 0, 0);
    add_req(REQ_HIT, 0, 0, '1, '1, '1);
    add_req(REQ_HIT, 0, 0, 30'd999999999, '1, 0);
    add_req(REQ_HIT, 0, 0, 30'd999999999, 0, 0);
    add_req(REQ_CLOSE, 0, 0, 0, 0, 0);
    add_req(REQ_OPEN, 0, 0, 0, 0, 0);
    add_req(REQ_HIT, 0, 0, 30'd700000000, 3, 2);
    add_req(REQ_HIT, 0, 0, 30'd100, 1, 0);
    add_req(REQ_CLOSE, 0, 0, 0, 0, 0);
    add_req(REQ_OPEN, 64'd3000000000, 64'd3000000000, 0, 0, 0);
    add_req(REQ_CLOSE, 0, 0, 0, 0, 0);
    add_req(REQ_OPEN, 64'd1999999999, 64'd2000000001, 0, 0, 0);
    add_req(REQ_HIT, 0, 0, 30'd499999999, 0, 0);
    add_req(REQ_HIT, 0, 0, 30'd500000001, 0, 0);
    add_req(REQ_CLOSE, 0, 0, 0, 0, 0);
    drain();

    // settings from one extreme to the other, then random ones
    set_all_cfg(-999999999, 32'd1, 32'hFFFF_FFFF, 30'd0);
    run_polls(250);
    set_all_cfg(999999999, 32'hFFFF_FFFF, 32'd1, 30'h3FFF_FFFF);
    run_polls(250);
    calm = 1'b1;
    set_all_cfg(0, 32'd0, 32'd1000, 30'd1000000000);
    run_polls(250);
    calm = 1'b0;
    set_all_cfg(int'($urandom_range(0, 1999999998)) - 999999999,
                $urandom_range(1000, 500000000), $urandom_range(1, 1000000000), 30'($urandom));
    run_polls(300);
    set_all_cfg(int'($urandom_range(0, 1999999998)) - 999999999, $urandom,
                $urandom, 30'($urandom_range(900000000, 1073741823)));
    run_polls(300);

    $display("covered %0d hit, %0d fragment and %0d summary results", n_hit_stamps,
             n_frag_stamps, n_summaries);
    $display("over five register settings with random idle and output stall");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
